FILE: hdl/lphs_pkg.sv
// ----------------------------------------------------------------------------
// lphs_pkg
// Shared types and constants of the linear-probing hash set.
// ----------------------------------------------------------------------------
package lphs_pkg;

    // Number of slots in the store and the index width that follows.
    localparam int SLOTS      = 1024;
    localparam int ADDR_W     = $clog2(SLOTS);
    localparam int KEY_W      = 64;

    // Limits of the table size register.
    localparam logic [4:0] LOG2_MIN   = 5'd3;
    localparam logic [4:0] LOG2_MAX   = 5'd10;
    localparam logic [4:0] SLOTS_LOG2 = 5'(ADDR_W);
    localparam logic [3:0] LOG2_RESET = 4'd10;

    // Register addresses on the configuration port.
    localparam logic [1:0] REG_ADDR_TABLE_SIZE = 2'd0;

    // Command codes.
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_CMP,
        ST_DONE
    } state_t;

    // Request from the sequencer to the slot memory.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [KEY_W-1:0]  wdata;
    } ram_req_t;

endpackage

FILE: hdl/lphs_slot_ram.sv
// ----------------------------------------------------------------------------
// lphs_slot_ram
// Single-port slot store with a registered read.
// ----------------------------------------------------------------------------
module lphs_slot_ram (
    input  logic                      clk,
    input  lphs_pkg::ram_req_t        req,
    output logic [lphs_pkg::KEY_W-1:0] rdata
);

    logic [lphs_pkg::KEY_W-1:0] mem [lphs_pkg::SLOTS];
    logic [lphs_pkg::KEY_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
    end

    // Registered read of the addressed slot, every cycle.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[req.addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/lphs_ctrl.sv
// ----------------------------------------------------------------------------
// lphs_ctrl
// Probe sequencer: walks the probe chain one slot at a time through a shared
// key comparator, runs the clearing sweep and holds the result register.
// ----------------------------------------------------------------------------
module lphs_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  command,
    input  logic [lphs_pkg::KEY_W-1:0]  key,
    input  logic [lphs_pkg::ADDR_W-1:0] mask,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        found,
    output logic                        table_full,
    output lphs_pkg::ram_req_t          ram_req,
    input  logic [lphs_pkg::KEY_W-1:0]  ram_rdata
);

    lphs_pkg::state_t state_reg, state_next;

    logic [1:0]                  cmd_reg, cmd_next;
    logic [lphs_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [lphs_pkg::ADDR_W-1:0] idx_reg, idx_next;
    logic [lphs_pkg::ADDR_W-1:0] cnt_reg, cnt_next;
    logic                        clr_reply_reg, clr_reply_next;
    logic                        zero_flag_reg, zero_flag_next;
    logic                        res_found_reg, res_found_next;
    logic                        res_full_reg, res_full_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_found_reg, out_found_next;
    logic                        out_full_reg, out_full_next;

    logic [lphs_pkg::KEY_W-1:0]  cmp_a, cmp_b;
    logic                        cmp_eq, cmp_a_zero;
    logic                        accept;

    // Shared comparator: the incoming key against zero when idle, else the
    // slot just read against the held key and against zero.
    always_comb
    begin
        cmp_a = (state_reg == lphs_pkg::ST_IDLE) ? key : ram_rdata;
        cmp_b = key_reg;
    end
    assign cmp_eq     = (cmp_a == cmp_b);
    assign cmp_a_zero = (cmp_a == '0);

    assign in_stall = (state_reg != lphs_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // State register and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lphs_pkg::ST_CLEAR;
            idx_reg       <= '0;
            clr_reply_reg <= 1'b0;
            zero_flag_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            clr_reply_reg <= clr_reply_next;
            zero_flag_reg <= zero_flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        cnt_reg       <= cnt_next;
        res_found_reg <= res_found_next;
        res_full_reg  <= res_full_next;
        out_found_reg <= out_found_next;
        out_full_reg  <= out_full_next;
    end

    // Next state and outputs.
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        clr_reply_next = clr_reply_reg;
        zero_flag_next = zero_flag_reg;
        res_found_next = res_found_reg;
        res_full_next  = res_full_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_found_next = out_found_reg;
        out_full_next  = out_full_reg;

        ram_req.we    = 1'b0;
        ram_req.addr  = idx_reg;
        ram_req.wdata = key_reg;

        unique case (state_reg)
            lphs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next       = command;
                    key_next       = key;
                    idx_next       = key[lphs_pkg::ADDR_W-1:0] & mask;
                    cnt_next       = '0;
                    res_found_next = 1'b0;
                    res_full_next  = 1'b0;
                    if (command == lphs_pkg::CMD_CLEAR)
                    begin
                        zero_flag_next = 1'b0;
                        idx_next       = '0;
                        clr_reply_next = 1'b1;
                        state_next     = lphs_pkg::ST_CLEAR;
                    end
                    else if (command == lphs_pkg::CMD_ADD ||
                             command == lphs_pkg::CMD_QUERY)
                    begin
                        if (cmp_a_zero)
                        begin
                            // The zero key lives in its own flag.
                            res_found_next = zero_flag_reg;
                            if (command == lphs_pkg::CMD_ADD)
                            begin
                                zero_flag_next = 1'b1;
                            end
                            state_next = lphs_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = lphs_pkg::ST_READ;
                        end
                    end
                    else
                    begin
                        // Unused command: no change, empty result.
                        state_next = lphs_pkg::ST_DONE;
                    end
                end
            end

            lphs_pkg::ST_CLEAR:
            begin
                ram_req.we    = 1'b1;
                ram_req.wdata = '0;
                idx_next      = idx_reg + 1'b1;
                if (idx_reg == '1)
                begin
                    idx_next       = '0;
                    clr_reply_next = 1'b0;
                    res_found_next = 1'b0;
                    res_full_next  = 1'b0;
                    state_next     = clr_reply_reg ? lphs_pkg::ST_DONE : lphs_pkg::ST_IDLE;
                end
            end

            lphs_pkg::ST_READ:
            begin
                state_next = lphs_pkg::ST_CMP;
            end

            lphs_pkg::ST_CMP:
            begin
                if (cmp_a_zero)
                begin
                    // Free slot ends the chain; an add claims it.
                    ram_req.we = (cmd_reg == lphs_pkg::CMD_ADD);
                    state_next = lphs_pkg::ST_DONE;
                end
                else if (cmp_eq)
                begin
                    res_found_next = 1'b1;
                    state_next     = lphs_pkg::ST_DONE;
                end
                else if (cnt_reg == mask)
                begin
                    // One full pass without a match or a free slot.
                    res_full_next = (cmd_reg == lphs_pkg::CMD_ADD);
                    state_next    = lphs_pkg::ST_DONE;
                end
                else
                begin
                    idx_next   = (idx_reg + 1'b1) & mask;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = lphs_pkg::ST_READ;
                end
            end

            lphs_pkg::ST_DONE:
            begin
                // Move the result into the output register once it is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_full_next  = res_full_reg;
                    state_next     = lphs_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lphs_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign found      = out_found_reg;
    assign table_full = out_full_reg;

endmodule

FILE: hdl/linear_probe_hash_set.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_set
// Membership set of 64-bit keys in an open-addressing table, linear probing.
//
// Items enter on the in channel (command, key) and each gives exactly one
// beat on the out channel (found, table_full). A beat moves at a rising edge
// where valid is high and stall is low. The block takes one item at a time:
// in_stall is high from the accepted beat until the result has been loaded
// into the output register, which then waits for the receiver on its own
// while the next item is taken.
// An add or a query with a nonzero key reads slots along the probe chain;
// each slot costs one read of the single-port slot memory and one pass
// through the shared key comparator. The zero key and the unused command
// read no slot. A clear sweeps all 1024 slots, one per cycle.
// After reset the same sweep runs and in_stall stays high; configuration
// writes are taken as ever. The table size register (byte address 0) sets
// the probed part of the table; it is to be written only while the block
// is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module linear_probe_hash_set (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [1:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 command,
    input  logic [lphs_pkg::KEY_W-1:0] key,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       found,
    output logic                       table_full
);

    logic [3:0]                  size_log2_reg;
    logic [4:0]                  lg_clamp;
    logic [4:0]                  lg_eff;
    logic [lphs_pkg::ADDR_W:0]   size_w;
    logic [lphs_pkg::ADDR_W:0]   size_m1;
    logic [lphs_pkg::ADDR_W-1:0] mask;
    logic                        cfg_write;

    lphs_pkg::ram_req_t          ram_req;
    logic [lphs_pkg::KEY_W-1:0]  ram_rdata;

    // Configuration register write.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr == lphs_pkg::REG_ADDR_TABLE_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg <= lphs_pkg::LOG2_RESET;
        end
        else if (cfg_write)
        begin
            size_log2_reg <= pwdata[3:0];
        end
    end

    // Register read back.
    always_comb
    begin
        prdata = '0;
        if (paddr == lphs_pkg::REG_ADDR_TABLE_SIZE)
        begin
            prdata = {28'd0, size_log2_reg};
        end
    end

    // Effective size: clamp to the legal range, then to the store depth.
    always_comb
    begin
        lg_clamp = {1'b0, size_log2_reg};
        if (lg_clamp < lphs_pkg::LOG2_MIN)
        begin
            lg_clamp = lphs_pkg::LOG2_MIN;
        end
        else if (lg_clamp > lphs_pkg::LOG2_MAX)
        begin
            lg_clamp = lphs_pkg::LOG2_MAX;
        end
        lg_eff = (lg_clamp > lphs_pkg::SLOTS_LOG2) ? lphs_pkg::SLOTS_LOG2 : lg_clamp;
    end

    // Probe mask is the table size minus one.
    assign size_w  = (lphs_pkg::ADDR_W+1)'(1) << lg_eff;
    assign size_m1 = size_w - (lphs_pkg::ADDR_W+1)'(1);
    assign mask    = size_m1[lphs_pkg::ADDR_W-1:0];

    lphs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .key        (key),
        .mask       (mask),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .found      (found),
        .table_full (table_full),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata)
    );

    lphs_slot_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

endmodule

FILE: hdl/lphs_checker.sv
// ----------------------------------------------------------------------------
// lphs_checker
// Port-level checks of the hash set, bound to the top level.
// ----------------------------------------------------------------------------
module lphs_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic                       found,
    input logic                       table_full
);

    // The block works on one item at a time.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("input taken again right after an accepted beat");

    // A result is never both a hit and a full table.
    a_found_excl_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> !(found && table_full)
    ) else $error("found and table_full both set");

    // A stalled result beat stays.
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid
    ) else $error("result beat dropped under stall");

    // A stalled result beat keeps its payload.
    a_out_stable: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(found) && $stable(table_full))
    ) else $error("result payload changed under stall");

endmodule

bind linear_probe_hash_set lphs_checker u_lphs_checker (.*);

FILE: tb/lphs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphs_scoreboard
// Scoreboard for the linear-probing hash set. It follows configuration writes
// and accepted beats, keeps its own copy of the slot table and the zero-key
// flag, predicts found and table_full for every command, and compares each
// result beat against the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module lphs_scoreboard (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [1:0]                 paddr,
    input  logic [31:0]                pwdata,
    input  logic                       pready,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [1:0]                 command,
    input  logic [lphs_pkg::KEY_W-1:0] key,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic                       found,
    input  logic                       table_full,
    output int                         pending,
    output int                         errors
);

    typedef struct packed {
        logic found;
        logic table_full;
    } answer_t;

    // Outcome of one walk along a probe chain.
    typedef enum logic [1:0] {
        CHAIN_HIT,
        CHAIN_FREE,
        CHAIN_FULL
    } chain_t;

    logic [lphs_pkg::KEY_W-1:0] slot_mem [lphs_pkg::SLOTS];
    logic                       zero_present;
    logic [3:0]                 size_log2;
    answer_t                    answer_q [$];

    // Empty every slot and forget the zero key.
    function automatic void wipe_set();
        int i;
        for (i = 0; i < lphs_pkg::SLOTS; i++)
        begin
            slot_mem[i] = '0;
        end
        zero_present = 1'b0;
    endfunction

    // Number of slots probed: the register clamped to its legal range and
    // never more than the store holds.
    function automatic int unsigned probe_span();
        int lg;
        lg = size_log2;
        if (lg < int'(lphs_pkg::LOG2_MIN))
        begin
            lg = lphs_pkg::LOG2_MIN;
        end
        if (lg > int'(lphs_pkg::LOG2_MAX))
        begin
            lg = lphs_pkg::LOG2_MAX;
        end
        while (lg > 0 && (1 << lg) > lphs_pkg::SLOTS)
        begin
            lg--;
        end
        return 1 << lg;
    endfunction

    // Walk from the home slot of a nonzero key for at most one full pass.
    function automatic chain_t walk_chain(input logic [lphs_pkg::KEY_W-1:0] k,
                                          output int unsigned pos);
        int unsigned n_slots;
        int unsigned mask;
        int unsigned idx;
        int unsigned n;
        n_slots = probe_span();
        mask    = n_slots - 1;
        idx     = k[31:0] & mask;
        pos     = 0;
        for (n = 0; n < n_slots; n++)
        begin
            if (slot_mem[idx] == '0)
            begin
                pos = idx;
                return CHAIN_FREE;
            end
            if (slot_mem[idx] == k)
            begin
                pos = idx;
                return CHAIN_HIT;
            end
            idx = (idx + 1) & mask;
        end
        return CHAIN_FULL;
    endfunction

    // Apply one command to the shadow set and return the answer it gives.
    function automatic answer_t apply_command(input logic [1:0] cmd,
                                              input logic [lphs_pkg::KEY_W-1:0] k);
        answer_t     a;
        chain_t      c;
        int unsigned pos;
        a = '0;
        unique case (cmd)
            lphs_pkg::CMD_ADD:
            begin
                if (k == '0)
                begin
                    a.found      = zero_present;
                    zero_present = 1'b1;
                end
                else
                begin
                    c = walk_chain(k, pos);
                    if (c == CHAIN_HIT)
                    begin
                        a.found = 1'b1;
                    end
                    else if (c == CHAIN_FREE)
                    begin
                        slot_mem[pos] = k;
                    end
                    else
                    begin
                        a.table_full = 1'b1;
                    end
                end
            end
            lphs_pkg::CMD_QUERY:
            begin
                if (k == '0)
                begin
                    a.found = zero_present;
                end
                else
                begin
                    a.found = (walk_chain(k, pos) == CHAIN_HIT);
                end
            end
            lphs_pkg::CMD_CLEAR:
            begin
                wipe_set();
            end
            default:
            begin
            end
        endcase
        return a;
    endfunction

    // Track register writes, predict on every input beat, check every
    // result beat.
    always @(posedge clk or negedge rst_n)
    begin : watch
        answer_t want;
        int      new_errors;
        if (!rst_n)
        begin
            wipe_set();
            size_log2 = lphs_pkg::LOG2_RESET;
            answer_q.delete();
            pending <= 0;
            errors  <= 0;
        end
        else
        begin
            new_errors = 0;
            if (psel && penable && pwrite && pready &&
                paddr == lphs_pkg::REG_ADDR_TABLE_SIZE)
            begin
                size_log2 = pwdata[3:0];
            end
            if (in_valid && !in_stall)
            begin
                answer_q.push_back(apply_command(command, key));
            end
            if (out_valid && !out_stall)
            begin
                if (answer_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, found %0b table_full %0b",
                             $time, found, table_full);
                    new_errors++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (found !== want.found)
                    begin
                        $display("%0t: found mismatch, expected %0b, actual %0b",
                                 $time, want.found, found);
                        new_errors++;
                    end
                    if (table_full !== want.table_full)
                    begin
                        $display("%0t: table_full mismatch, expected %0b, actual %0b",
                                 $time, want.table_full, table_full);
                        new_errors++;
                    end
                end
            end
            pending <= answer_q.size();
            errors  <= errors + new_errors;
        end
    end

endmodule

FILE: tb/linear_probe_hash_set_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_set_tb
// Stimulus and verdict for the linear-probing hash set. A directed opening
// covers the zero key, wrap-around of the probe chain, clear, the unused
// command and a full table; random phases then sweep the table size register
// through legal and out-of-range values; two idle both channels at random.
// ----------------------------------------------------------------------------
module linear_probe_hash_set_tb;

    localparam logic [1:0]  CMD_UNUSED    = 2'd3;
    localparam int          STALL_LIMIT   = 20000;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          SEGMENT_ITEMS = 85;
    localparam logic [63:0] FILL_BASE     = 64'h1357_9BDF_0000_0007;

    // Table size written before each random segment, entry 0 in the low bits.
    localparam logic [71:0] SIZE_PLAN = {4'd3, 4'd10, 4'd0, 4'd15, 4'd5, 4'd8,
                                         4'd4, 4'd12, 4'd7, 4'd1, 4'd9, 4'd6,
                                         4'd10, 4'd3, 4'd14, 4'd2, 4'd11, 4'd13};

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [1:0]                 paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       in_valid;
    logic                       in_stall;
    logic [1:0]                 command;
    logic [lphs_pkg::KEY_W-1:0] key;
    logic                       out_valid;
    logic                       out_stall;
    logic                       found;
    logic                       table_full;

    int                         pending;
    int                         errors;
    int                         quiet_cycles;
    int                         send_idle_pct;
    int                         rcv_idle_pct;
    bit                         hold_req;
    logic [lphs_pkg::KEY_W-1:0] key_pool [$];

    linear_probe_hash_set u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .key        (key),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .found      (found),
        .table_full (table_full)
    );

    lphs_scoreboard u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .key        (key),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .found      (found),
        .table_full (table_full),
        .pending    (pending),
        .errors     (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Offer one beat, with random idle cycles first, and wait until taken.
    task automatic send_item(input logic [1:0] c, input logic [lphs_pkg::KEY_W-1:0] k);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= c;
        key      <= k;
        do @(posedge clk); while (in_stall);
    endtask

    // Stop offering and wait until every predicted result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Setup and access cycle on the configuration port; junk in the
    // unused upper bits.
    task automatic write_size(input logic [3:0] v);
        logic [31:0] junk;
        junk = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lphs_pkg::REG_ADDR_TABLE_SIZE;
        pwdata  <= {junk[31:4], v};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Receiver: random stalls, and one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    // Watchdog on cycles in which no beat moves on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[linear_probe_hash_set] ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main stimulus.
    initial
    begin : stimulus
        int                         i;
        int                         phase;
        int                         seg;
        int                         n;
        int                         roll;
        logic [1:0]                 c;
        logic [lphs_pkg::KEY_W-1:0] k;

        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        command       = lphs_pkg::CMD_ADD;
        key           = '0;
        out_stall     = 1'b0;
        quiet_cycles  = 0;
        hold_req      = 1'b0;
        send_idle_pct = 38;
        rcv_idle_pct  = 51;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Zero key, wrap from the top slot to slot 0, unused command, clear.
        send_item(lphs_pkg::CMD_QUERY, '0);
        send_item(lphs_pkg::CMD_ADD, '0);
        send_item(lphs_pkg::CMD_ADD, '0);
        send_item(lphs_pkg::CMD_QUERY, '0);
        send_item(lphs_pkg::CMD_ADD, '1);
        send_item(lphs_pkg::CMD_ADD, 64'h8000_0000_0000_03FF);
        send_item(lphs_pkg::CMD_QUERY, 64'h8000_0000_0000_03FF);
        send_item(lphs_pkg::CMD_ADD, '1);
        send_item(lphs_pkg::CMD_QUERY, 64'h1);
        send_item(CMD_UNUSED, '1);
        send_item(lphs_pkg::CMD_CLEAR, '1);
        send_item(lphs_pkg::CMD_QUERY, '1);
        send_item(lphs_pkg::CMD_QUERY, '0);

        // Smallest table: fill all eight slots from one home slot, then
        // add and query against the full table.
        drain();
        write_size(4'd3);
        for (i = 0; i < 9; i++)
        begin
            send_item(lphs_pkg::CMD_ADD, FILL_BASE + 64'(i) * 64'h100);
        end
        send_item(lphs_pkg::CMD_QUERY, FILL_BASE + 64'd9 * 64'h100);
        send_item(lphs_pkg::CMD_QUERY, FILL_BASE);
        send_item(lphs_pkg::CMD_ADD, FILL_BASE);

        // Random phases: receiver idles more, then sender, then neither.
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 51 : 0;
            rcv_idle_pct  = (phase == 0) ? 51 : (phase == 1) ? 38 : 0;
            for (seg = 0; seg < 6; seg++)
            begin
                drain();
                write_size(SIZE_PLAN[4 * (phase * 6 + seg) +: 4]);
                if (phase == 0 && seg == 1)
                begin
                    hold_req = 1'b1;
                end
                for (n = 0; n < SEGMENT_ITEMS; n++)
                begin
                    roll = $urandom_range(99);
                    if (roll < 46)
                    begin
                        c = lphs_pkg::CMD_ADD;
                    end
                    else if (roll < 94)
                    begin
                        c = lphs_pkg::CMD_QUERY;
                    end
                    else if (roll < 96)
                    begin
                        c = lphs_pkg::CMD_CLEAR;
                    end
                    else
                    begin
                        c = CMD_UNUSED;
                    end
                    // Reuse earlier keys for hits; cluster fresh keys near
                    // the top and bottom of the table for long chains.
                    roll = $urandom_range(99);
                    if (roll < 40 && key_pool.size() != 0)
                    begin
                        k = key_pool[$urandom_range(key_pool.size() - 1)];
                    end
                    else if (roll < 46)
                    begin
                        k = '0;
                    end
                    else
                    begin
                        k = {$urandom, $urandom};
                        if (roll < 72)
                        begin
                            k[9:0] = 10'h3F0 + 10'($urandom_range(15));
                        end
                        else if (roll < 85)
                        begin
                            k[9:0] = 10'($urandom_range(31));
                        end
                    end
                    send_item(c, k);
                    if (c == lphs_pkg::CMD_ADD && k != '0)
                    begin
                        key_pool.push_back(k);
                        if (key_pool.size() > 64)
                        begin
                            key_pool.pop_front();
                        end
                    end
                end
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("[linear_probe_hash_set] OK");
        end
        else
        begin
            $display("[linear_probe_hash_set] ERROR");
        end
        $finish;
    end

endmodule
